FILE: hw/rtl/ufrb_pkg.sv
package ufrb_pkg;

    localparam int DATA_W   = 8;
    localparam int BUS_W    = 16;
    localparam int OFS_W    = 12;
    localparam int OPCODE_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [OPCODE_W-1:0] OP_BUS_READ  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BUS_WRITE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LINE_RX   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_TX_READY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_EN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_EN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIFO_EN   = 2'd3;

    localparam logic [OFS_W-1:0] OFS_DATA  = 12'h000;
    localparam logic [OFS_W-1:0] OFS_FLAGS = 12'h018;
    localparam logic [OFS_W-1:0] OFS_ICR   = 12'h044;

    localparam logic [BUS_W-1:0] FLAG_RXFE   = 16'h0010;
    localparam logic [BUS_W-1:0] FLAG_TXFF   = 16'h0020;
    localparam logic [BUS_W-1:0] FLAG_RXFF   = 16'h0040;
    localparam logic [BUS_W-1:0] FLAG_TXFE   = 16'h0080;
    localparam logic [BUS_W-1:0] OVERRUN_BIT = 16'h0800;

    typedef struct packed {
        logic rx_empty;
        logic rx_full;
        logic tx_empty;
        logic tx_full;
        logic overrun;
        logic device_en;
        logic tx_en;
        logic rx_en;
    } status_t;

    typedef struct packed {
        logic             tx_push;
        logic             tx_pop;
        logic             rx_push;
        logic             rx_pop;
        logic             ovr_set;
        logic             ovr_clr;
        logic [BUS_W-1:0] rd_base;
    } cmd_t;

endpackage

FILE: hw/rtl/ufrb_queue.sv
module ufrb_queue #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cap_one,
    input  logic                        push,
    input  logic [ufrb_pkg::DATA_W-1:0] push_byte,
    input  logic                        pop,
    output logic [ufrb_pkg::DATA_W-1:0] pop_byte,
    output logic                        empty,
    output logic                        full
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    logic [ufrb_pkg::DATA_W-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ufrb_pkg::DATA_W-1:0] pop_byte_reg;

    assign empty = (count_reg == '0);
    // one-byte mode: anything held counts as full, also after a shrink
    assign full  = cap_one ? !empty : (count_reg >= CNT_FULL);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (pop)
        begin
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_byte;
        end
        if (pop)
        begin
            pop_byte_reg <= mem[head_reg];
        end
    end

    assign pop_byte = pop_byte_reg;

endmodule

FILE: hw/rtl/ufrb_decode.sv
module ufrb_decode (
    input  logic [ufrb_pkg::OPCODE_W-1:0] opcode,
    input  logic [ufrb_pkg::OFS_W-1:0]    reg_offset,
    input  ufrb_pkg::status_t             status,
    output ufrb_pkg::cmd_t                cmd
);

    always_comb
    begin
        cmd = '0;
        unique case (opcode)
            ufrb_pkg::OP_BUS_READ:
            begin
                if (reg_offset == ufrb_pkg::OFS_DATA)
                begin
                    if (!status.rx_empty)
                    begin
                        cmd.rx_pop  = 1'b1;
                        cmd.rd_base = status.overrun ? ufrb_pkg::OVERRUN_BIT : '0;
                    end
                end
                else if (reg_offset == ufrb_pkg::OFS_FLAGS)
                begin
                    cmd.rd_base = (status.rx_empty ? ufrb_pkg::FLAG_RXFE : '0)
                                | (status.tx_full  ? ufrb_pkg::FLAG_TXFF : '0)
                                | (status.rx_full  ? ufrb_pkg::FLAG_RXFF : '0)
                                | (status.tx_empty ? ufrb_pkg::FLAG_TXFE : '0);
                end
            end
            ufrb_pkg::OP_BUS_WRITE:
            begin
                if (reg_offset == ufrb_pkg::OFS_DATA)
                begin
                    cmd.tx_push = !status.tx_full;
                end
                else if (reg_offset == ufrb_pkg::OFS_ICR)
                begin
                    cmd.ovr_clr = 1'b1;
                end
            end
            ufrb_pkg::OP_LINE_RX:
            begin
                if (status.device_en && status.rx_en)
                begin
                    cmd.ovr_set = status.rx_full;
                    cmd.rx_push = !status.rx_full;
                end
            end
            ufrb_pkg::OP_TX_READY:
            begin
                cmd.tx_pop = status.device_en && status.tx_en && !status.tx_empty;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/uart_fifo_register_block.sv
// An accepted input beat moves through the s1 and s2 registers to out_valid.
// Throughput: one beat per cycle while in_stall is low; FIFO state and the
// registered FIFO read port update at the accept edge, s2 when it takes s1.
// Reset: rst_n is asynchronous active low; pointers, counts, overrun and
// pipeline valids clear, enables return to device off, tx on, rx on, FIFO off.
// FIFO storage is not reset.
module uart_fifo_register_block #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ufrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ufrb_pkg::OPCODE_W-1:0]  opcode,
    input  logic [ufrb_pkg::OFS_W-1:0]     reg_offset,
    input  logic [ufrb_pkg::BUS_W-1:0]     write_data,
    input  logic [ufrb_pkg::DATA_W-1:0]    line_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ufrb_pkg::BUS_W-1:0]     read_data,
    output logic                           tx_valid,
    output logic [ufrb_pkg::DATA_W-1:0]    tx_byte
);

    logic device_en_reg, tx_en_reg, rx_en_reg, fifo_en_reg;
    logic overrun_reg;

    logic s1_valid_reg;
    logic s1_rx_pop_reg, s1_tx_pop_reg;
    logic [ufrb_pkg::BUS_W-1:0] s1_base_reg;

    logic s2_valid_reg;
    logic [ufrb_pkg::BUS_W-1:0]  s2_rdata_reg;
    logic                        s2_txv_reg;
    logic [ufrb_pkg::DATA_W-1:0] s2_txb_reg;

    logic accept, s2_take, s1_move;
    ufrb_pkg::status_t status;
    ufrb_pkg::cmd_t    cmd;

    logic tx_push, tx_pop, rx_push, rx_pop;
    logic tx_empty, tx_full, rx_empty, rx_full;
    logic [ufrb_pkg::DATA_W-1:0] tx_q_byte, rx_q_byte;

    assign s2_take  = !s2_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && s2_take;
    assign in_stall = s1_valid_reg && !s2_take;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_en_reg <= 1'b0;
            tx_en_reg     <= 1'b1;
            rx_en_reg     <= 1'b1;
            fifo_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ufrb_pkg::CFG_DEVICE_EN: device_en_reg <= cfg_wdata;
                ufrb_pkg::CFG_TX_EN:     tx_en_reg     <= cfg_wdata;
                ufrb_pkg::CFG_RX_EN:     rx_en_reg     <= cfg_wdata;
                ufrb_pkg::CFG_FIFO_EN:   fifo_en_reg   <= cfg_wdata;
                default:                 fifo_en_reg   <= fifo_en_reg;
            endcase
        end
    end

    always_comb
    begin
        status.rx_empty  = rx_empty;
        status.rx_full   = rx_full;
        status.tx_empty  = tx_empty;
        status.tx_full   = tx_full;
        status.overrun   = overrun_reg;
        status.device_en = device_en_reg;
        status.tx_en     = tx_en_reg;
        status.rx_en     = rx_en_reg;
    end

    ufrb_decode u_decode (
        .opcode     (opcode),
        .reg_offset (reg_offset),
        .status     (status),
        .cmd        (cmd)
    );

    assign tx_push = accept && cmd.tx_push;
    assign tx_pop  = accept && cmd.tx_pop;
    assign rx_push = accept && cmd.rx_push;
    assign rx_pop  = accept && cmd.rx_pop;

    ufrb_queue #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_tx_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_one   (!fifo_en_reg),
        .push      (tx_push),
        .push_byte (write_data[ufrb_pkg::DATA_W-1:0]),
        .pop       (tx_pop),
        .pop_byte  (tx_q_byte),
        .empty     (tx_empty),
        .full      (tx_full)
    );

    ufrb_queue #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_one   (!fifo_en_reg),
        .push      (rx_push),
        .push_byte (line_byte),
        .pop       (rx_pop),
        .pop_byte  (rx_q_byte),
        .empty     (rx_empty),
        .full      (rx_full)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overrun_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && cmd.ovr_set)
            begin
                overrun_reg <= 1'b1;
            end
            else if (accept && cmd.ovr_clr)
            begin
                overrun_reg <= 1'b0;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_take)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // queue read registers hold the popped byte alongside the s1 sideband
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rx_pop_reg <= cmd.rx_pop;
            s1_tx_pop_reg <= cmd.tx_pop;
            s1_base_reg   <= cmd.rd_base;
        end
        if (s1_move)
        begin
            s2_rdata_reg <= s1_base_reg
                          | (s1_rx_pop_reg ? {{(ufrb_pkg::BUS_W - ufrb_pkg::DATA_W){1'b0}},
                                              rx_q_byte} : '0);
            s2_txv_reg   <= s1_tx_pop_reg;
            s2_txb_reg   <= s1_tx_pop_reg ? tx_q_byte : '0;
        end
    end

    assign out_valid = s2_valid_reg;
    assign read_data = s2_rdata_reg;
    assign tx_valid  = s2_txv_reg;
    assign tx_byte   = s2_txb_reg;

endmodule

FILE: hw/rtl/ufrb_checker.sv
module ufrb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [ufrb_pkg::BUS_W-1:0]  read_data,
    input logic                        tx_valid,
    input logic [ufrb_pkg::DATA_W-1:0] tx_byte
);

    // async reset must empty the output stage
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
                                   && $stable(tx_valid) && $stable(tx_byte))
        else $error("stalled result beat changed");

    // a beat is either a bus read or a line send, never both
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid |-> read_data == '0)
        else $error("tx beat carries read data");

    a_no_tx_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == '0)
        else $error("tx_byte set without tx_valid");

    a_rdata_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> read_data[15:12] == 4'h0 && read_data[10:8] == 3'h0)
        else $error("read_data has undefined bits set");

endmodule

bind uart_fifo_register_block ufrb_checker u_checker (.*);

FILE: dv/tb_uart_fifo_register_block.sv
`timescale 1ns / 1ps

module tb_uart_fifo_register_block;

    import ufrb_pkg::*;

    localparam int FIFO_DEPTH     = 32;
    localparam int N_PHASES       = 10;
    localparam int PHASE_BEATS    = 200;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [OFS_W-1:0] OFS_UNMAPPED = 12'hFFF;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [OFS_W-1:0]    ofs;
        logic [BUS_W-1:0]    wdata;
        logic [DATA_W-1:0]   lbyte;
    } beat_t;

    typedef struct packed {
        logic [BUS_W-1:0]  read_data;
        logic              tx_valid;
        logic [DATA_W-1:0] tx_byte;
    } result_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        bit                   val;
        beat_t                beat;
        bit                   chk;
        result_t              want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_wdata = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OPCODE_W-1:0]  opcode = '0;
    logic [OFS_W-1:0]     reg_offset = '0;
    logic [BUS_W-1:0]     write_data = '0;
    logic [DATA_W-1:0]    line_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [BUS_W-1:0]     read_data;
    logic                 tx_valid;
    logic [DATA_W-1:0]    tx_byte;

    uart_fifo_register_block #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .reg_offset(reg_offset),
        .write_data(write_data),
        .line_byte (line_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow of the block state, reset values
    logic [DATA_W-1:0] tx_mem [FIFO_DEPTH];
    logic [DATA_W-1:0] rx_mem [FIFO_DEPTH];
    int tx_head = 0;
    int tx_count = 0;
    int rx_head = 0;
    int rx_count = 0;
    bit ovr_mark = 1'b0;
    bit en_dev = 1'b0;
    bit en_tx = 1'b1;
    bit en_rx = 1'b1;
    bit en_fifo = 1'b0;

    result_t    uart_results_q[$];
    dir_row_t   dir_tab[$];
    idle_mode_t idle_mode = IDLE_NONE;
    bit         hold_req = 1'b0;
    int         hold_left = 0;

    int errors = 0;
    int beats_in = 0;
    int results_out = 0;
    int bytes_sent = 0;
    int overruns = 0;
    int peak_tx = 0;
    int peak_rx = 0;
    int in_stalls = 0;
    int quiet = 0;

    function automatic int fifo_cap();
        return en_fifo ? FIFO_DEPTH : 1;
    endfunction

    function automatic result_t predict_uart(beat_t b);
        result_t r;
        r = '0;
        case (b.op)
            OP_BUS_READ:
            begin
                if (b.ofs == OFS_DATA)
                begin
                    if (rx_count != 0)
                    begin
                        r.read_data = {8'h00, rx_mem[rx_head]} | (ovr_mark ? OVERRUN_BIT : '0);
                        rx_head = (rx_head + 1) % FIFO_DEPTH;
                        rx_count--;
                    end
                end
                else if (b.ofs == OFS_FLAGS)
                begin
                    if (rx_count == 0)
                        r.read_data |= FLAG_RXFE;
                    if (tx_count >= fifo_cap())
                        r.read_data |= FLAG_TXFF;
                    if (rx_count >= fifo_cap())
                        r.read_data |= FLAG_RXFF;
                    if (tx_count == 0)
                        r.read_data |= FLAG_TXFE;
                end
            end
            OP_BUS_WRITE:
            begin
                if (b.ofs == OFS_DATA)
                begin
                    if (tx_count < fifo_cap())
                    begin
                        tx_mem[(tx_head + tx_count) % FIFO_DEPTH] = b.wdata[DATA_W-1:0];
                        tx_count++;
                    end
                end
                else if (b.ofs == OFS_ICR)
                    ovr_mark = 1'b0;
            end
            OP_LINE_RX:
            begin
                if (en_dev && en_rx)
                begin
                    if (rx_count >= fifo_cap())
                    begin
                        ovr_mark = 1'b1;
                        overruns++;
                    end
                    else
                    begin
                        rx_mem[(rx_head + rx_count) % FIFO_DEPTH] = b.lbyte;
                        rx_count++;
                    end
                end
            end
            default:
            begin
                if (en_dev && en_tx && tx_count != 0)
                begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = tx_mem[tx_head];
                    tx_head = (tx_head + 1) % FIFO_DEPTH;
                    tx_count--;
                    bytes_sent++;
                end
            end
        endcase
        if (tx_count > peak_tx)
            peak_tx = tx_count;
        if (rx_count > peak_rx)
            peak_rx = rx_count;
        return r;
    endfunction

    function automatic beat_t rand_beat(mix_t mix);
        beat_t b;
        int r;
        int s;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  b.op = (r < 35) ? OP_BUS_WRITE : (r < 70) ? OP_LINE_RX :
                              (r < 85) ? OP_BUS_READ : OP_TX_READY;
            MIX_DRAIN: b.op = (r < 35) ? OP_BUS_READ : (r < 70) ? OP_TX_READY :
                              (r < 85) ? OP_BUS_WRITE : OP_LINE_RX;
            default:   b.op = OPCODE_W'($urandom_range(0, 3));
        endcase
        s = $urandom_range(0, 99);
        if (s < 50)
            b.ofs = OFS_DATA;
        else if (s < 75)
            b.ofs = OFS_FLAGS;
        else if (s < 85)
            b.ofs = OFS_ICR;
        else
            b.ofs = OFS_W'($urandom_range(0, 4095));
        b.wdata = BUS_W'($urandom_range(0, 65535));
        b.lbyte = DATA_W'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void add_beat(logic [OPCODE_W-1:0] op, logic [OFS_W-1:0] ofs,
                                     logic [BUS_W-1:0] wd, logic [DATA_W-1:0] lb, bit chk,
                                     logic [BUS_W-1:0] rd, logic tv, logic [DATA_W-1:0] tb);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.idx = '0;
        row.val = 1'b0;
        row.beat = {op, ofs, wd, lb};
        row.chk = chk;
        row.want = {rd, tv, tb};
        dir_tab.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, bit val);
        dir_row_t row;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.val = val;
        row.beat = '0;
        row.chk = 1'b0;
        row.want = '0;
        dir_tab.push_back(row);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        errors++;
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 results_out, what, got, want);
    endtask

    // register writes only with nothing in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit val);
        in_valid <= 1'b0;
        while (uart_results_q.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_DEVICE_EN: en_dev = val;
            CFG_TX_EN:     en_tx = val;
            CFG_RX_EN:     en_rx = val;
            default:       en_fifo = val;
        endcase
    endtask

    task automatic send_beat(beat_t b, bit chk, result_t want);
        int gap;
        int pct;
        result_t r;
        gap = 0;
        pct = (idle_mode == IDLE_SEND) ? 77 : (idle_mode == IDLE_BOTH) ? 11 : 0;
        while ($urandom_range(0, 99) < pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= b.op;
        reg_offset <= b.ofs;
        write_data <= b.wdata;
        line_byte <= b.lbyte;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        r = predict_uart(b);
        uart_results_q.push_back(chk ? want : r);
        beats_in++;
    endtask

    task automatic check_result();
        result_t want;
        if (uart_results_q.size() == 0)
            report_mismatch("result with nothing pending, read_data", read_data, 0);
        else
        begin
            want = uart_results_q.pop_front();
            if (read_data !== want.read_data)
                report_mismatch("read_data", read_data, want.read_data);
            if (tx_valid !== want.tx_valid)
                report_mismatch("tx_valid", tx_valid, want.tx_valid);
            if (tx_byte !== want.tx_byte)
                report_mismatch("tx_byte", tx_byte, want.tx_byte);
        end
        results_out++;
    endtask

    // result side: check the beat, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            check_result();
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (idle_mode == IDLE_RECV)
            out_stall <= ($urandom_range(0, 99) < 77);
        else if (idle_mode == IDLE_BOTH)
            out_stall <= ($urandom_range(0, 99) < 11);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (in_valid === 1'b1 && in_stall === 1'b1)
            in_stalls++;
        if ((in_valid === 1'b1 && in_stall === 1'b0)
            || (out_valid === 1'b1 && out_stall === 1'b0))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("timeout: %0d cycles without a beat", quiet);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        bit de;
        bit te;
        bit re;
        bit fe;
        mix_t mix;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of reset: device off, tx/rx on, one-byte holding registers
        add_beat(OP_BUS_READ,  OFS_FLAGS,    16'h0000, 8'h00, 1, FLAG_RXFE | FLAG_TXFE, 0, 8'h00);
        add_beat(OP_BUS_READ,  OFS_DATA,     16'h0000, 8'h00, 1, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_READ,  OFS_ICR,      16'h0000, 8'h00, 1, 16'h0000, 0, 8'h00);
        add_beat(OP_LINE_RX,   OFS_DATA,     16'h0000, 8'hFF, 1, 16'h0000, 0, 8'h00);
        add_beat(OP_TX_READY,  OFS_DATA,     16'h0000, 8'h00, 1, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_WRITE, OFS_DATA,     16'hFFFF, 8'h00, 1, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_WRITE, OFS_DATA,     16'h0000, 8'h00, 1, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_READ,  OFS_FLAGS,    16'h0000, 8'h00, 1, FLAG_RXFE | FLAG_TXFF, 0, 8'h00);
        add_beat(OP_TX_READY,  OFS_DATA,     16'h0000, 8'h00, 1, 16'h0000, 0, 8'h00);
        add_cfg(CFG_DEVICE_EN, 1'b1);
        add_beat(OP_TX_READY,  OFS_DATA,     16'h0000, 8'h00, 1, 16'h0000, 1, 8'hFF);
        add_beat(OP_TX_READY,  OFS_DATA,     16'h0000, 8'h00, 1, 16'h0000, 0, 8'h00);
        // second byte finds the holding register full -> overrun
        add_beat(OP_LINE_RX,   OFS_DATA,     16'h0000, 8'h00, 0, 16'h0000, 0, 8'h00);
        add_beat(OP_LINE_RX,   OFS_DATA,     16'h0000, 8'hA5, 0, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_READ,  OFS_FLAGS,    16'h0000, 8'h00, 1, FLAG_RXFF | FLAG_TXFE, 0, 8'h00);
        add_beat(OP_BUS_READ,  OFS_DATA,     16'h0000, 8'h00, 1, OVERRUN_BIT, 0, 8'h00);
        add_beat(OP_BUS_WRITE, OFS_ICR,      16'hFFFF, 8'h00, 0, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_WRITE, OFS_UNMAPPED, 16'hFFFF, 8'h00, 0, 16'h0000, 0, 8'h00);
        add_beat(OP_LINE_RX,   OFS_DATA,     16'h0000, 8'h5A, 0, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_READ,  OFS_DATA,     16'h0000, 8'h00, 1, 16'h005A, 0, 8'h00);
        // fill two deep, then shrink capacity under the held bytes
        add_cfg(CFG_FIFO_EN, 1'b1);
        add_beat(OP_BUS_WRITE, OFS_DATA,     16'h0011, 8'h00, 0, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_WRITE, OFS_DATA,     16'h0022, 8'h00, 0, 16'h0000, 0, 8'h00);
        add_cfg(CFG_FIFO_EN, 1'b0);
        add_beat(OP_BUS_WRITE, OFS_DATA,     16'h0033, 8'h00, 0, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_READ,  OFS_FLAGS,    16'h0000, 8'h00, 1, FLAG_RXFE | FLAG_TXFF, 0, 8'h00);
        add_cfg(CFG_TX_EN, 1'b0);
        add_beat(OP_TX_READY,  OFS_DATA,     16'h0000, 8'h00, 1, 16'h0000, 0, 8'h00);
        add_cfg(CFG_TX_EN, 1'b1);
        add_beat(OP_TX_READY,  OFS_DATA,     16'h0000, 8'h00, 1, 16'h0000, 1, 8'h11);
        add_beat(OP_TX_READY,  OFS_DATA,     16'h0000, 8'h00, 1, 16'h0000, 1, 8'h22);
        add_cfg(CFG_RX_EN, 1'b0);
        add_beat(OP_LINE_RX,   OFS_DATA,     16'h0000, 8'h77, 1, 16'h0000, 0, 8'h00);
        add_beat(OP_BUS_READ,  OFS_FLAGS,    16'h0000, 8'h00, 1, FLAG_RXFE | FLAG_TXFE, 0, 8'h00);
        add_cfg(CFG_RX_EN, 1'b1);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            else
                send_beat(dir_tab[i].beat, dir_tab[i].chk, dir_tab[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            idle_mode = idle_mode_t'(p % 4);
            mix = mix_t'(p % 3);
            if (p == 0 || p == PRESSURE_PHASE)
                {de, te, re, fe} = 4'b1111;
            else if (p == 1)
                {de, te, re, fe} = 4'b0000;
            else
            begin
                de = ($urandom_range(0, 99) < 85);
                te = ($urandom_range(0, 99) < 80);
                re = ($urandom_range(0, 99) < 80);
                fe = ($urandom_range(0, 99) < 70);
            end
            write_reg(CFG_DEVICE_EN, de);
            write_reg(CFG_TX_EN, te);
            write_reg(CFG_RX_EN, re);
            write_reg(CFG_FIFO_EN, fe);
            // long output hold while the sender keeps offering beats
            if (p == PRESSURE_PHASE)
                hold_req = 1'b1;
            repeat (PHASE_BEATS) send_beat(rand_beat(mix), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (uart_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats in, %0d results out, %0d phases of idle/config mix, %0d %s",
                 beats_in, results_out, N_PHASES, in_stalls, "input stalls");
        $display("line side: %0d bytes sent, %0d overruns, peak fill tx %0d rx %0d, %0d errors",
                 bytes_sent, overruns, peak_tx, peak_rx, errors);
        if (errors == 0 && uart_results_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
